// ----- src/sbc_pkg.sv -----
// ============================================================================
// Scanline band counter package
// Field widths, register indexes and saturation limits shared by the design.
// ============================================================================
package sbc_pkg;

    localparam int COLOR_W   = 8;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1;

    localparam int THRESH_W = 9;
    localparam int MIN_W    = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam int RUN_W    = 10;
    localparam int REGION_W = 11;
    localparam int POS_W    = 10;
    localparam int SUM_W    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_WIDTH  = 1'd1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd128;
    localparam logic [MIN_W-1:0]    MIN_RESET    = 10'd5;

    localparam logic [RUN_W-1:0]    RUN_MAX      = 10'd1023;
    localparam logic [REGION_W-1:0] REGION_MAX   = 11'd1025;
    localparam logic [REGION_W-1:0] REGION_RESET = 11'd1;
    localparam logic [REGION_W-1:0] REGION_START = 11'd2;
    localparam logic [REGION_W-1:0] REGION_END   = 11'd3;

    typedef struct packed {
        logic [COLOR_W-1:0] blue_level;
        logic [COLOR_W-1:0] green_level;
        logic [COLOR_W-1:0] red_level;
    } pixel_t;

endpackage

// ----- src/scanline_band_counter_top.sv -----
// ============================================================================
// Scanline band counter
// Thresholds each RGB pixel of a scanline and counts wide light/dark bands,
// reporting the band count and the start and end positions per line.
// ============================================================================
//
//  channel   direction  beat contents
//  s_*       in         tdata: red[7:0], green[15:8], blue[23:16]; tlast: line end
//  m_*       out        tdata: band_total, start_index, end_index; tuser: pair_found
//  cfg_*     in         index 0 dark_threshold, index 1 minimum run width
//
//  A pixel beat is taken every cycle while the input does not stall. It is
//  registered in the input register and updates the line state from there;
//  a line-end beat also loads the result register with the line's result.
//  Only a line-end pixel waits on the result register, and the input stalls
//  only while it waits. Reset clears the line state and loads the defaults.
//
module scanline_band_counter_top #(
    parameter int MAX_LINE_LENGTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // red_level, green_level, blue_level
    input  logic [sbc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // band_total, start_index, end_index, zero fill
    output logic [sbc_pkg::OUT_DATA_W-1:0] m_tdata,
    // pair_found
    output logic [sbc_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                           cfg_we,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbc_pkg::CFG_W-1:0]      cfg_data
);
    import sbc_pkg::*;

    localparam int PosMaxInt = (MAX_LINE_LENGTH - 1 < 1023) ? MAX_LINE_LENGTH - 1 : 1023;
    localparam logic [POS_W-1:0] PosMax = POS_W'(PosMaxInt);

    logic [THRESH_W-1:0] thresh_reg;
    logic [MIN_W-1:0]    min_width_reg;

    pixel_t pix_reg;
    logic   pix_last_reg;
    logic   pix_valid_reg;

    logic                dark_run_reg, dark_run_next;
    logic [RUN_W-1:0]    run_width_reg, run_width_next;
    logic [REGION_W-1:0] region_reg, region_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [POS_W-1:0]    end_reg, end_next;

    logic                out_valid_reg;
    logic [REGION_W-1:0] out_count_reg;
    logic                out_pair_reg;
    logic [POS_W-1:0]    out_start_reg;
    logic [POS_W-1:0]    out_end_reg;

    logic                out_free;
    logic                pix_go;
    logic                emit;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W:0]      thresh_x3;
    logic                dark;
    logic [REGION_W-1:0] region_upd;
    logic [POS_W-1:0]    start_upd;
    logic [POS_W-1:0]    end_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            min_width_reg <= MIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DARK_THRESHOLD)
            begin
                thresh_reg <= cfg_data[THRESH_W-1:0];
            end
            if (cfg_index == REG_MIN_RUN_WIDTH)
            begin
                min_width_reg <= cfg_data[MIN_W-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign pix_go   = pix_valid_reg && (!pix_last_reg || out_free);
    assign emit     = pix_valid_reg && pix_last_reg && out_free;
    assign s_tready = !pix_valid_reg || pix_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            pix_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pix_reg      <= pixel_t'(s_tdata);
            pix_last_reg <= s_tlast;
        end
    end

    // gray < T is the same as r + g + b < 3 * T for the truncated average.
    assign sum = SUM_W'(pix_reg.red_level) + SUM_W'(pix_reg.green_level)
               + SUM_W'(pix_reg.blue_level);
    assign thresh_x3 = (SUM_W+1)'(thresh_reg) + {1'b0, thresh_reg, 1'b0};
    assign dark = ({1'b0, sum} < thresh_x3);

    always_comb
    begin
        region_upd = region_reg;
        start_upd  = start_reg;
        end_upd    = end_reg;
        dark_run_next  = dark_run_reg;
        run_width_next = run_width_reg;
        if (dark == dark_run_reg)
        begin
            if (run_width_reg < RUN_MAX)
            begin
                run_width_next = run_width_reg + 1'b1;
            end
        end
        else
        begin
            dark_run_next  = dark;
            run_width_next = '0;
            if (run_width_reg > min_width_reg && region_reg < REGION_MAX)
            begin
                region_upd = region_reg + 1'b1;
            end
            if (region_upd == REGION_START)
            begin
                start_upd = pos_reg;
            end
            if (region_upd >= REGION_END)
            begin
                end_upd = pos_reg;
            end
        end

        region_next = region_upd;
        start_next  = start_upd;
        end_next    = end_upd;
        pos_next    = pos_reg;
        if (pix_last_reg)
        begin
            dark_run_next  = 1'b0;
            run_width_next = '0;
            region_next    = REGION_RESET;
            pos_next       = '0;
            start_next     = '0;
            end_next       = '0;
        end
        else if (pos_reg < PosMax)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_run_reg  <= 1'b0;
            run_width_reg <= '0;
            region_reg    <= REGION_RESET;
            pos_reg       <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
        end
        else if (pix_go)
        begin
            dark_run_reg  <= dark_run_next;
            run_width_reg <= run_width_next;
            region_reg    <= region_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_count_reg <= region_upd - REGION_START;
            out_pair_reg  <= (region_upd >= REGION_END);
            out_start_reg <= start_upd;
            out_end_reg   <= end_upd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_end_reg, out_start_reg, out_count_reg};
    assign m_tuser  = out_pair_reg;

endmodule
